// ===== design/particle_lifetime_integrator_unit_macros.svh =====
// Assertion macros for the particle lifetime integrator
`ifndef PARTICLE_LIFETIME_INTEGRATOR_UNIT_MACROS_SVH
`define PARTICLE_LIFETIME_INTEGRATOR_UNIT_MACROS_SVH
`define PLI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/pli_pkg.sv =====
// Package: types, constants and codes of the particle lifetime integrator
`timescale 1ns / 1ps
package pli_pkg;
  localparam int unsigned LifeW = 12;
  localparam int unsigned QuoW = 17;
  localparam logic [17:0] OneQ16 = 18'd65536;

  localparam logic [1:0] ModeNone = 2'd0;
  localparam logic [1:0] ModeDown = 2'd1;
  localparam logic [1:0] ModeUp = 2'd2;
  localparam logic [1:0] ModeSmoke = 2'd3;

  localparam logic [2:0] RegAccelX = 3'd0;
  localparam logic [2:0] RegAccelY = 3'd1;
  localparam logic [2:0] RegAccelZ = 3'd2;
  localparam logic [2:0] RegSpin = 3'd3;
  localparam logic [2:0] RegLife = 3'd4;
  localparam logic [2:0] RegModes = 3'd5;
  localparam logic [2:0] RegBounce = 3'd6;
  localparam logic [2:0] RegElast = 3'd7;

  localparam logic CmdInit = 1'b0;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [17:0]        size_factor;
    logic signed [19:0] alpha;
    logic signed [31:0] angle;
    logic               alive;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle, StDiv, StSmoke, StPhys, StMove, StOut
  } state_e;

  typedef struct packed {
    logic init;
    logic div_start;
    logic div_step;
    logic smoke;
    logic phys;
    logic move;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic live;
    logic div_done;
  } status_t;
endpackage

// ===== design/pli_datapath.sv =====
// Datapath: state registers, serial divider, bounce and move arithmetic
`timescale 1ns / 1ps
module pli_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pli_pkg::cmd_t     cmd_i,
  output pli_pkg::status_t  status_o,
  input  pli_pkg::in_item_t in_item_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  output pli_pkg::out_item_t out_item_o
);
  import pli_pkg::*;

  logic [31:0] ax_q, ay_q, az_q, spin_q;
  logic [11:0] life_q;
  logic [3:0]  modes_q;
  logic        bounce_q;
  logic [17:0] elast_q;

  logic [11:0] age_q, age_d;
  logic [31:0] px_q, py_q, pz_q, vx_q, vy_q, vz_q, ang_q;
  logic [17:0] scale_q;
  logic signed [19:0] alpha_q;
  logic        live_q;

  logic [27:0] rem_q;
  logic [QuoW-1:0] quo_q;
  logic [4:0]  cnt_q;
  logic [27:0] sub_w;
  logic [11:0] lifed;

  logic signed [12:0] dage;
  logic [23:0] dsq;
  logic [23:0] dsq_q, dsq_p_q;
  logic [48:0] prod1;
  logic [7:0]  qa_q, qa_p_q, qa_pp_q;
  logic [16:0] rb_q;
  logic [26:0] n2_q;
  logic [54:0] prod2;
  logic [42:0] term_q;
  logic signed [43:0] op;
  logic signed [31:0] vyn;
  logic signed [32:0] nvy;
  logic signed [51:0] bp;
  logic        rest;
  logic signed [31:0] pys;

  assign lifed = (life_q == '0) ? 12'd1 : life_q;
  assign sub_w = {rem_q[26:0], 1'b0} - {15'd0, lifed, 1'b0};
  assign age_d = age_q + 12'd1;
  assign status_o.live = (age_q < life_q);
  assign status_o.div_done = (cnt_q == 5'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0; ay_q <= '0; az_q <= '0; spin_q <= '0;
      life_q <= '0; modes_q <= '0; bounce_q <= 1'b0; elast_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAccelX: ax_q <= cfg_data_i;
        RegAccelY: ay_q <= cfg_data_i;
        RegAccelZ: az_q <= cfg_data_i;
        RegSpin:   spin_q <= cfg_data_i;
        RegLife:   life_q <= cfg_data_i[11:0];
        RegModes:  modes_q <= cfg_data_i[3:0];
        RegBounce: bounce_q <= cfg_data_i[0];
        RegElast:  elast_q <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // restoring divider: quotient of age<<16 by life, one bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= 5'(QuoW);
    end else if (cmd_i.div_step && cnt_q != '0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= {16'd0, age_d};
      quo_q <= '0;
    end else if (cmd_i.div_step && cnt_q != '0) begin
      if (!sub_w[27]) begin
        rem_q <= sub_w;
        quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[26:0], 1'b0};
        quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
    end
  end

  // divisor is twice life: 17 steps of age*2^17 / (2*life) give age*2^16 / life
  assign dage = $signed({1'b0, age_q}) - 13'sd700;
  assign dsq = 24'(dage) * 24'(dage);

  // smoke term round(d*d*196608/10^7) = floor((1536*d*d + 39062) / 78125),
  // split as d*d = 78125*a + b and divided by reciprocal multiplication
  assign prod1 = 49'(dsq_q) * 49'd28147498;
  assign prod2 = 55'(n2_q) * 55'd225179982;

  always_ff @(posedge clk_i) begin
    dsq_q <= dsq;
    dsq_p_q <= dsq_q;
    qa_q <= prod1[48:41];
    qa_p_q <= qa_q;
    rb_q <= 17'(dsq_p_q - 24'(qa_q) * 24'd78125);
    qa_pp_q <= qa_p_q;
    n2_q <= 27'({rb_q, 10'd0}) + 27'({rb_q, 9'd0}) + 27'd39062;
    term_q <= 43'({qa_pp_q, 10'd0}) + 43'({qa_pp_q, 9'd0}) + 43'(prod2[54:44]);
  end

  always_comb begin
    unique case (modes_q[3:2])
      ModeDown: op = 44'sd65536 - $signed({27'd0, quo_q[QuoW-1:1]});
      ModeUp:   op = $signed({27'd0, quo_q[QuoW-1:1]});
      ModeSmoke: op = 44'sd39322 - $signed({1'b0, term_q});
      default:  op = 44'sd65536;
    endcase
  end

  assign pys = $signed(py_q);
  assign nvy = -$signed({vy_q[31], vy_q});
  assign bp = nvy * $signed({1'b0, elast_q});
  always_comb begin
    vyn = $signed(vy_q);
    if (pys < 0) vyn = bp[47:16];
    rest = (vyn >= -32) && (vyn <= 32) && (pys >= -6553) && (pys <= 6553);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0; px_q <= '0; py_q <= '0; pz_q <= '0;
      vx_q <= '0; vy_q <= '0; vz_q <= '0; ang_q <= '0;
      scale_q <= OneQ16; alpha_q <= 20'sd65536; live_q <= 1'b0;
    end else begin
      if (cmd_i.init) begin
        px_q <= in_item_i.pos_x; py_q <= in_item_i.pos_y; pz_q <= in_item_i.pos_z;
        vx_q <= in_item_i.vel_x; vy_q <= in_item_i.vel_y; vz_q <= in_item_i.vel_z;
        age_q <= '0; ang_q <= '0;
      end
      if (cmd_i.div_start) age_q <= age_d;
      if (cmd_i.smoke) begin
        vx_q <= vx_q + ax_q; vy_q <= vy_q + ay_q; vz_q <= vz_q + az_q;
        unique case (modes_q[1:0])
          ModeDown:  scale_q <= OneQ16 - 18'(quo_q);
          ModeUp:    scale_q <= 18'(quo_q);
          ModeSmoke: scale_q <= 18'd131072 + 18'(quo_q);
          default:   scale_q <= OneQ16;
        endcase
      end
      if (cmd_i.phys) begin
        if (op > 44'sd524287) alpha_q <= 20'sd524287;
        else if (op < -44'sd524288) alpha_q <= -20'sd524288;
        else alpha_q <= op[19:0];
        if (bounce_q) begin
          if (rest) begin
            vx_q <= {vx_q[31], vx_q[31:1]};
            vy_q <= {vyn[31], vyn[31:1]};
            vz_q <= {vz_q[31], vz_q[31:1]};
          end else begin
            vy_q <= vyn;
          end
        end
      end
      if (cmd_i.move) begin
        px_q <= px_q + vx_q; py_q <= py_q + vy_q; pz_q <= pz_q + vz_q;
        ang_q <= ang_q + spin_q;
      end
      if (cmd_i.out_load) live_q <= status_o.live;
    end
  end

  assign out_item_o.out_x = px_q;
  assign out_item_o.out_y = py_q;
  assign out_item_o.out_z = pz_q;
  assign out_item_o.size_factor = scale_q;
  assign out_item_o.alpha = alpha_q;
  assign out_item_o.angle = ang_q;
  assign out_item_o.alive = live_q;
endmodule

// ===== design/pli_ctrl.sv =====
// Controller: sequences init, divide, update and result handshake
`timescale 1ns / 1ps
module pli_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pli_pkg::status_t status_i,
  output pli_pkg::cmd_t    cmd_o
);
  import pli_pkg::*;
  `include "particle_lifetime_integrator_unit_macros.svh"

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == CmdInit) begin
            cmd_o.init = 1'b1;
            state_d = StMove;
          end else if (status_i.live) begin
            cmd_o.div_start = 1'b1;
            state_d = StDiv;
          end else begin
            state_d = StMove;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) state_d = StSmoke;
      end
      StSmoke: begin
        cmd_o.smoke = 1'b1;
        state_d = StPhys;
      end
      StPhys: begin
        cmd_o.phys = 1'b1;
        cmd_o.move = 1'b0;
        state_d = StMove;
      end
      StMove: begin
        cmd_o.out_load = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  `PLI_ASSERT(a_one_side, clk_i, rst_ni, !(in_ready_o && out_valid_o), "both sides open")
  `PLI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o,
                   "result dropped")
  `PLI_ASSERT(a_div_end, clk_i, rst_ni, (state_q == StSmoke) |-> status_i.div_done,
              "divider not done")
endmodule

// ===== design/particle_lifetime_integrator_unit.sv =====
// Top level: particle lifetime integrator
// Init or dead tick: after the input item is taken, the result is loaded in StMove and shown
// in StOut; a live tick first runs the 17-step serial divider, then update, physics, move.
// Flow: one item in flight; a new item is taken only after the result has been accepted.
// Reset: asynchronous active low; config zero, state zero, scale and alpha 1.0.
`timescale 1ns / 1ps
module particle_lifetime_integrator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pli_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pli_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  import pli_pkg::*;

  cmd_t    cmd;
  status_t status;

  pli_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_cmd_i(in_item_i.cmd),
    .out_valid_o, .out_ready_i, .status_i(status), .cmd_o(cmd)
  );

  logic move_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) move_q <= 1'b0;
    else move_q <= cmd.phys;
  end

  cmd_t cmd_dp;
  always_comb begin
    cmd_dp = cmd;
    cmd_dp.move = move_q;
  end

  pli_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd_dp), .status_o(status), .in_item_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .out_item_o
  );
endmodule
